@@ hw/rtl/clws_pkg.sv @@
// Shared definitions for the character-LCD write sequencer.
// Holds request codes, fixed LCD bytes and field widths.
// No dependencies.
package clws_pkg;

  // Field widths
  localparam int OPCODE_W = 3;
  localparam int BYTE_W   = 8;
  localparam int COLUMN_W = 6;
  localparam int NUMBER_W = 16;
  localparam int SLOT_W   = 3;
  localparam int PATTERN_W = 64;

  // Decimal conversion: five BCD digits cover a 16-bit value.
  localparam int DIGITS   = 5;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int BITCNT_W = $clog2(NUMBER_W);
  localparam int DIGCNT_W = $clog2(DIGITS + 1);

  // Request codes
  localparam logic [OPCODE_W-1:0] OP_INIT    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DATA    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_CMD     = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POS     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_NUMBER  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_SPECIAL = 3'd5;

  // Fixed LCD bytes
  localparam logic [BYTE_W-1:0] LCD_FUNC_SET   = 8'b0011_1000;
  localparam logic [BYTE_W-1:0] LCD_DISP_ON    = 8'b0000_1100;
  localparam logic [BYTE_W-1:0] LCD_CLEAR      = 8'b0000_0001;
  localparam logic [3:0]        ASCII_DIGIT_HI = 4'h3;

  // Register-select codes
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Steps of the special-character run
  localparam logic [3:0] SP_CGRAM   = 4'd0;
  localparam logic [3:0] SP_ROW_END = 4'd8;
  localparam logic [3:0] SP_POS     = 4'd9;
  localparam logic [3:0] SP_SLOT    = 4'd10;

endpackage

@@ hw/rtl/clws_bin2bcd.sv @@
// Bit-serial binary to BCD converter (shift and add three).
// One input bit per cycle. Uses clws_pkg.
module clws_bin2bcd (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [clws_pkg::NUMBER_W-1:0] value,
  output logic                          done,
  output logic [clws_pkg::BCD_W-1:0]    bcd
);
  import clws_pkg::*;

  logic [NUMBER_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [BITCNT_W-1:0] cnt_r, cnt_nxt;
  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [BCD_W-1:0]    bcd_adj;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  // One bit of the binary value moves into the BCD word each cycle.
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt = value;
      bcd_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[NUMBER_W-1]};
      bin_nxt = {bin_r[NUMBER_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == BITCNT_W'(NUMBER_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

@@ hw/rtl/char_lcd_write_sequencer.sv @@
// Top level of the character-LCD write sequencer.
// Expands one display request into a run of bus writes. Uses clws_pkg, clws_bin2bcd.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+------------------------
//   request  | in_opcode .. in_pattern_rows            | start high, busy low
//   write    | out_reg_select, out_bus_byte, out_last  | out_valid, one cycle
//
// Writes leave one per cycle from an output register while emitting, but a
// number's leading zeros give none. Init gives three writes, data, command
// and position one, special character eleven. A number first waits for the
// bit-serial BCD converter to shift in every bit, then steps through its digits.
// Unused opcodes are taken and give no write.
// Reset is synchronous and active low; the receiver cannot stall the block.
module char_lcd_write_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [clws_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [clws_pkg::BYTE_W-1:0]    in_byte_value,
  input  logic                           in_row,
  input  logic [clws_pkg::COLUMN_W-1:0]  in_column,
  input  logic [clws_pkg::NUMBER_W-1:0]  in_number,
  input  logic [clws_pkg::SLOT_W-1:0]    in_char_slot,
  input  logic [clws_pkg::PATTERN_W-1:0] in_pattern_rows,
  output logic                           out_valid,
  output logic                           out_reg_select,
  output logic [clws_pkg::BYTE_W-1:0]    out_bus_byte,
  output logic                           out_last
);
  import clws_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic [3:0]          step_r, step_nxt;
  logic [DIGCNT_W-1:0] rem_r, rem_nxt;
  logic [PATTERN_W-1:0] pat_r, pat_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [BYTE_W-1:0]   pos_r, pos_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;

  logic                valid_r, valid_nxt;
  logic                rs_r, rs_nxt;
  logic [BYTE_W-1:0]   bus_r, bus_nxt;
  logic                last_r, last_nxt;

  logic                accept;
  logic                conv_start;
  logic                conv_done;
  logic [BCD_W-1:0]    conv_bcd;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign conv_start = accept && (in_opcode == OP_NUMBER);

  clws_bin2bcd u_bin2bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .value (in_number),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // Sequencer: one bus write per cycle while emitting, but none for a leading zero.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    pat_nxt   = pat_r;
    slot_nxt  = slot_r;
    pos_nxt   = pos_r;
    byte_nxt  = byte_r;
    bcd_nxt   = bcd_r;
    valid_nxt = 1'b0;
    rs_nxt    = rs_r;
    bus_nxt   = bus_r;
    last_nxt  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_opcode;
          step_nxt = '0;
          pat_nxt  = in_pattern_rows;
          slot_nxt = in_char_slot;
          byte_nxt = in_byte_value;
          // Column is below 64, so the position command is a concatenation.
          pos_nxt  = {1'b1, in_row, in_column};
          if (in_opcode == OP_NUMBER) begin
            state_nxt = ST_CONV;
          end else if (in_opcode <= OP_SPECIAL) begin
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_CONV: begin
        if (conv_done) begin
          bcd_nxt   = conv_bcd;
          rem_nxt   = DIGCNT_W'(DIGITS);
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        step_nxt = step_r + 4'd1;
        unique case (op_r)
          OP_INIT: begin
            valid_nxt = 1'b1;
            rs_nxt    = RS_CMD;
            if (step_r == 4'd0) begin
              bus_nxt = LCD_FUNC_SET;
            end else if (step_r == 4'd1) begin
              bus_nxt = LCD_DISP_ON;
            end else begin
              bus_nxt  = LCD_CLEAR;
              last_nxt = 1'b1;
            end
          end
          OP_DATA: begin
            valid_nxt = 1'b1;
            rs_nxt    = RS_DATA;
            bus_nxt   = byte_r;
            last_nxt  = 1'b1;
          end
          OP_CMD: begin
            valid_nxt = 1'b1;
            rs_nxt    = RS_CMD;
            bus_nxt   = byte_r;
            last_nxt  = 1'b1;
          end
          OP_POS: begin
            valid_nxt = 1'b1;
            rs_nxt    = RS_CMD;
            bus_nxt   = pos_r;
            last_nxt  = 1'b1;
          end
          OP_NUMBER: begin
            // Leading zeros are shifted out without a write; the last digit stays.
            bcd_nxt = {bcd_r[BCD_W-5:0], 4'h0};
            rem_nxt = rem_r - 1'b1;
            if (bcd_r[BCD_W-1 -: 4] != 4'h0 || rem_r == DIGCNT_W'(1) || step_r[3]) begin
              valid_nxt = 1'b1;
              rs_nxt    = RS_DATA;
              bus_nxt   = {ASCII_DIGIT_HI, bcd_r[BCD_W-1 -: 4]};
              last_nxt  = (rem_r == DIGCNT_W'(1));
              // Once a digit is written, every later digit is written too.
              step_nxt  = 4'd8;
            end
          end
          OP_SPECIAL: begin
            valid_nxt = 1'b1;
            if (step_r == SP_CGRAM) begin
              rs_nxt  = RS_CMD;
              bus_nxt = {2'b01, slot_r, 3'b000};
            end else if (step_r <= SP_ROW_END) begin
              rs_nxt  = RS_DATA;
              bus_nxt = pat_r[BYTE_W-1:0];
              pat_nxt = {{BYTE_W{1'b0}}, pat_r[PATTERN_W-1:BYTE_W]};
            end else if (step_r == SP_POS) begin
              rs_nxt  = RS_CMD;
              bus_nxt = pos_r;
            end else begin
              rs_nxt   = RS_DATA;
              bus_nxt  = {{(BYTE_W-SLOT_W){1'b0}}, slot_r};
              last_nxt = 1'b1;
            end
          end
          default: begin
            valid_nxt = 1'b0;
            last_nxt  = 1'b1;
          end
        endcase
        if (last_nxt) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state is reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    op_r   <= op_nxt;
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    pat_r  <= pat_nxt;
    slot_r <= slot_nxt;
    pos_r  <= pos_nxt;
    byte_r <= byte_nxt;
    bcd_r  <= bcd_nxt;
    rs_r   <= rs_nxt;
    bus_r  <= bus_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_reg_select = rs_r;
  assign out_bus_byte   = bus_r;
  assign out_last       = last_r && valid_r;

  // A write only follows a cycle in which a request was in progress.
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("write issued without a request in progress");

  // The final write of a request leaves the block free for the next one.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("block still busy after final write");

  // The converter only finishes while the sequencer waits for it.
  a_conv_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> (state_r == ST_CONV))
    else $error("conversion finished outside the conversion wait");

  // Nothing is written while a conversion is running.
  a_quiet_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |=> !out_valid)
    else $error("write issued during conversion");

endmodule

@@ bench/tb_char_lcd_write_sequencer.sv @@
// Self-checking testbench for the character-LCD write sequencer.
// Depends on clws_pkg and char_lcd_write_sequencer; predicts every bus write
// from each accepted request item and checks the write stream in order.
module tb_char_lcd_write_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import clws_pkg::*;

  // Spare request codes, which the block takes and drops
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  // LCD bytes built from request fields
  localparam logic [BYTE_W-1:0] DDRAM_CMD_BASE = 8'h80;
  localparam logic [BYTE_W-1:0] ROW1_OFFSET    = 8'h40;
  localparam logic [BYTE_W-1:0] CGRAM_CMD_BASE = 8'h40;
  localparam logic [BYTE_W-1:0] ASCII_ZERO     = 8'h30;

  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTED  = 30;

  typedef struct {
    logic [OPCODE_W-1:0]  opcode;
    logic [BYTE_W-1:0]    byte_value;
    logic                 row;
    logic [COLUMN_W-1:0]  column;
    logic [NUMBER_W-1:0]  number;
    logic [SLOT_W-1:0]    char_slot;
    logic [PATTERN_W-1:0] pattern_rows;
  } lcd_request_t;

  typedef struct {
    logic              reg_select;
    logic [BYTE_W-1:0] bus_byte;
    logic              is_last;
  } bus_write_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [OPCODE_W-1:0]  in_opcode;
  logic [BYTE_W-1:0]    in_byte_value;
  logic                 in_row;
  logic [COLUMN_W-1:0]  in_column;
  logic [NUMBER_W-1:0]  in_number;
  logic [SLOT_W-1:0]    in_char_slot;
  logic [PATTERN_W-1:0] in_pattern_rows;
  logic                 out_valid;
  logic                 out_reg_select;
  logic [BYTE_W-1:0]    out_bus_byte;
  logic                 out_last;

  bus_write_t  pending_writes[$];
  int unsigned error_count = 0;
  int unsigned idle_pct    = 0;

  char_lcd_write_sequencer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_byte_value   (in_byte_value),
    .in_row          (in_row),
    .in_column       (in_column),
    .in_number       (in_number),
    .in_char_slot    (in_char_slot),
    .in_pattern_rows (in_pattern_rows),
    .out_valid       (out_valid),
    .out_reg_select  (out_reg_select),
    .out_bus_byte    (out_bus_byte),
    .out_last        (out_last)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Appends one expected bus write.
  function automatic void push_write(input logic rs, input logic [BYTE_W-1:0] value);
    bus_write_t w;
    w.reg_select = rs;
    w.bus_byte   = value;
    w.is_last    = 1'b0;
    pending_writes.push_back(w);
  endfunction

  function automatic logic [BYTE_W-1:0] ddram_command(input logic row,
                                                      input logic [COLUMN_W-1:0] column);
    logic [BYTE_W-1:0] addr;
    addr = BYTE_W'(column);
    if (row) begin
      addr = addr + ROW1_OFFSET;
    end
    return addr + DDRAM_CMD_BASE;
  endfunction

  // Expands one accepted request into the bus writes it should cause.
  function automatic void expand_request(input lcd_request_t req);
    logic [BYTE_W-1:0] digits[DIGITS];
    int unsigned       ndig;
    int unsigned       v;
    int                first_idx;
    first_idx = pending_writes.size();
    case (req.opcode)
      OP_INIT: begin
        push_write(RS_CMD, LCD_FUNC_SET);
        push_write(RS_CMD, LCD_DISP_ON);
        push_write(RS_CMD, LCD_CLEAR);
      end
      OP_DATA: push_write(RS_DATA, req.byte_value);
      OP_CMD:  push_write(RS_CMD, req.byte_value);
      OP_POS:  push_write(RS_CMD, ddram_command(req.row, req.column));
      OP_NUMBER: begin
        // Least significant digit is found first; writes go out the other way round.
        v    = req.number;
        ndig = 0;
        do begin
          digits[ndig] = ASCII_ZERO + BYTE_W'(v % 10);
          v = v / 10;
          ndig++;
        end while (v != 0 && ndig < DIGITS);
        while (ndig > 0) begin
          ndig--;
          push_write(RS_DATA, digits[ndig]);
        end
      end
      OP_SPECIAL: begin
        push_write(RS_CMD, CGRAM_CMD_BASE + BYTE_W'({req.char_slot, 3'b000}));
        for (int i = 0; i < 8; i++) begin
          push_write(RS_DATA, req.pattern_rows[8*i +: 8]);
        end
        push_write(RS_CMD, ddram_command(req.row, req.column));
        push_write(RS_DATA, BYTE_W'(req.char_slot));
      end
      default: ;
    endcase
    if (pending_writes.size() > first_idx) begin
      pending_writes[pending_writes.size()-1].is_last = 1'b1;
    end
  endfunction

  // Sends one request item after a random gap, and records what it should cause.
  // Start is left high after acceptance; the next negedge either lowers it or
  // presents the next item, so it is never lowered and raised in one step.
  task automatic send_request(input lcd_request_t req);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start           <= 1'b1;
    in_opcode       <= req.opcode;
    in_byte_value   <= req.byte_value;
    in_row          <= req.row;
    in_column       <= req.column;
    in_number       <= req.number;
    in_char_slot    <= req.char_slot;
    in_pattern_rows <= req.pattern_rows;
    @(posedge clk);
    while (busy) @(posedge clk);
    expand_request(req);
  endtask

  // A request with every field random; the opcode is chosen by the caller.
  function automatic lcd_request_t random_request(input logic [OPCODE_W-1:0] op);
    lcd_request_t req;
    int unsigned  ndig;
    int unsigned  lo;
    int unsigned  hi;
    req.opcode       = op;
    req.byte_value   = BYTE_W'($urandom);
    req.row          = 1'($urandom);
    req.column       = COLUMN_W'($urandom);
    req.char_slot    = SLOT_W'($urandom);
    req.pattern_rows = {$urandom, $urandom};
    // Spread numbers evenly over digit counts, so short ones are not rare.
    ndig = $urandom_range(1, DIGITS);
    lo   = (ndig == 1) ? 0 : 10 ** (ndig - 1);
    hi   = (ndig == DIGITS) ? 65535 : 10 ** ndig - 1;
    req.number = NUMBER_W'($urandom_range(hi, lo));
    return req;
  endfunction

  // Compares each write with the oldest expectation.
  always @(posedge clk) begin : check_writes
    bus_write_t exp_w;
    if (rst_n && out_valid === 1'bx) begin
      report_mismatch("out_valid unknown");
    end else if (rst_n && out_valid) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write rs=%0b byte=%02h last=%0b",
                                  out_reg_select, out_bus_byte, out_last));
      end else begin
        exp_w = pending_writes.pop_front();
        if (out_reg_select !== exp_w.reg_select) begin
          report_mismatch($sformatf("reg_select %0b, expected %0b",
                                    out_reg_select, exp_w.reg_select));
        end
        if (out_bus_byte !== exp_w.bus_byte) begin
          report_mismatch($sformatf("bus_byte %02h, expected %02h",
                                    out_bus_byte, exp_w.bus_byte));
        end
        if (out_last !== exp_w.is_last) begin
          report_mismatch($sformatf("last %0b, expected %0b", out_last, exp_w.is_last));
        end
      end
    end
  end

  // Init, and data and command bytes at both extremes.
  task automatic test_fixed_bytes();
    lcd_request_t req;
    send_request(random_request(OP_INIT));
    req = random_request(OP_DATA);
    req.byte_value = '0;
    send_request(req);
    req.byte_value = '1;
    send_request(req);
    req = random_request(OP_CMD);
    req.byte_value = '0;
    send_request(req);
    req.byte_value = '1;
    send_request(req);
  endtask

  // Set position on both rows, including columns past the visible line.
  task automatic test_positions();
    lcd_request_t req;
    req = random_request(OP_POS);
    req.row = 1'b0; req.column = '0;
    send_request(req);
    req.row = 1'b1; req.column = COLUMN_W'(39);
    send_request(req);
    req.row = 1'b1; req.column = '1;
    send_request(req);
    req.row = 1'b0; req.column = '1;
    send_request(req);
  endtask

  // Zero, single digits and the widest values.
  task automatic test_numbers();
    lcd_request_t req;
    int unsigned  vals[6] = '{0, 9, 10, 1000, 10000, 65535};
    req = random_request(OP_NUMBER);
    foreach (vals[i]) begin
      req.number = NUMBER_W'(vals[i]);
      send_request(req);
    end
  endtask

  // Special characters in the first and last slot with flat patterns.
  task automatic test_special_chars();
    lcd_request_t req;
    req = random_request(OP_SPECIAL);
    req.char_slot = '0; req.pattern_rows = '0; req.row = 1'b0; req.column = '0;
    send_request(req);
    req.char_slot = '1; req.pattern_rows = '1; req.row = 1'b1; req.column = '1;
    send_request(req);
  endtask

  // Spare opcodes cause no write, but the block must keep going afterwards.
  task automatic test_spare_opcodes();
    send_request(random_request(OP_SPARE_LO));
    send_request(random_request(OP_SPARE_HI));
    send_request(random_request(OP_DATA));
  endtask

  // Random requests at a given sender idle rate; spare opcodes are not counted.
  task automatic test_random_requests(input int unsigned pct, input int unsigned count);
    int unsigned  sent;
    logic [OPCODE_W-1:0] op;
    idle_pct = pct;
    sent     = 0;
    while (sent < count) begin
      if ($urandom_range(11) == 0) begin
        op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      end else begin
        op = OPCODE_W'($urandom_range(OP_SPECIAL, OP_INIT));
        sent++;
      end
      send_request(random_request(op));
    end
    idle_pct = 0;
  endtask

  // Run limit
  initial begin
    #500us;
    $display("FAIL");
    $finish;
  end

  // Reset, tests in turn, then drain and verdict.
  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_opcode       = '0;
    in_byte_value   = '0;
    in_row          = 1'b0;
    in_column       = '0;
    in_number       = '0;
    in_char_slot    = '0;
    in_pattern_rows = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fixed_bytes();
    test_positions();
    test_numbers();
    test_special_chars();
    test_spare_opcodes();
    test_random_requests(0, 27);
    test_random_requests(66, 27);
    test_random_requests(20, 26);

    @(negedge clk);
    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/clws_pkg.sv
hw/rtl/clws_bin2bcd.sv
hw/rtl/char_lcd_write_sequencer.sv
bench/tb_char_lcd_write_sequencer.sv
